// ===== rtl/nrmc_pkg.sv =====
// Shared constants, types and helper functions of the RMC position parser.
package nrmc_pkg;

    localparam int MAX_LEN     = 128;
    localparam int FRAC_DIGITS = 5;
    localparam int CHAR_W      = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_E      = 8'h45;

    localparam logic [2:0] HDR_LEN = 3'd6;

    localparam logic [2:0] FLD_TIME   = 3'd0;
    localparam logic [2:0] FLD_STATUS = 3'd1;
    localparam logic [2:0] FLD_LAT    = 3'd2;
    localparam logic [2:0] FLD_NS     = 3'd3;
    localparam logic [2:0] FLD_LON    = 3'd4;
    localparam logic [2:0] FLD_EW     = 3'd5;
    localparam logic [2:0] FLD_MAX    = 3'd7;

    localparam logic [2:0] TIME_DIGITS = 3'd6;
    localparam logic [4:0] HOURS_MAX   = 5'd31;
    localparam logic [5:0] MINSEC_MAX  = 6'd63;

    localparam logic [31:0] LAT_ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] LON_ACC_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] LAT_LIMIT   = 32'd900000000;
    localparam logic [31:0] LON_LIMIT   = 32'd1800000000;

    localparam logic [16:0] INT_WEIGHT  = 17'd100000;
    localparam logic [19:0] TENS_WEIGHT = 20'd1000000;
    localparam logic [23:0] DEG_SCALE   = 24'd10000000;

    // Multiplying by this and dropping THIRD_SHIFT bits gives floor(5 * x / 3).
    localparam int          THIRD_SHIFT     = 27;
    localparam logic [27:0] FIVE_THIRDS_MUL = 28'd223696215;

    typedef struct packed {
        logic       clear;
        logic       int_en;
        logic       frac_en;
        logic [3:0] digit;
        logic [2:0] frac_idx;
    } digit_cmd_t;

    typedef struct packed {
        logic        at_max;
        logic [8:0]  deg;
        logic [23:0] rem;
    } coord_t;

    typedef struct packed {
        logic       present;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } utc_t;

    typedef struct packed {
        logic   active;
        logic   south;
        logic   west;
        utc_t   utc;
        coord_t lat;
        coord_t lon;
    } fix_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    function automatic logic [16:0] frac_weight(input logic [2:0] idx);
        logic [16:0] w;
        unique case (idx)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            3'd4:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/nrmc_coord_acc.sv =====
// Digit accumulator for one coordinate, kept both as a saturating count and as degree/minute parts.
module nrmc_coord_acc (
    input  logic                aclk,
    input  logic                aresetn,
    input  nrmc_pkg::digit_cmd_t cmd,
    input  logic [31:0]         sat_value,
    output nrmc_pkg::coord_t    coord
);
    import nrmc_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [8:0]  deg_reg, deg_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  units_reg, units_next;
    logic [16:0] frac_reg, frac_next;

    logic [35:0] int_sum;
    logic [16:0] frac_add;
    logic [32:0] frac_sum;

    always_comb begin
        int_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                 + 36'(cmd.digit) * 36'(INT_WEIGHT);
        frac_add = 17'(17'(cmd.digit) * frac_weight(cmd.frac_idx));
        frac_sum = {1'b0, acc_reg} + 33'(frac_add);

        acc_next   = acc_reg;
        deg_next   = deg_reg;
        tens_next  = tens_reg;
        units_next = units_reg;
        frac_next  = frac_reg;
        if (cmd.clear) begin
            acc_next   = '0;
            deg_next   = '0;
            tens_next  = '0;
            units_next = '0;
            frac_next  = '0;
        end else if (cmd.int_en) begin
            acc_next   = (int_sum > {4'b0000, sat_value}) ? sat_value : int_sum[31:0];
            deg_next   = 9'(deg_reg * 9'd10 + 9'(tens_reg));
            tens_next  = units_reg;
            units_next = cmd.digit;
        end else if (cmd.frac_en) begin
            acc_next  = (frac_sum > {1'b0, sat_value}) ? sat_value : frac_sum[31:0];
            frac_next = frac_reg + frac_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            deg_reg   <= '0;
            tens_reg  <= '0;
            units_reg <= '0;
            frac_reg  <= '0;
        end else begin
            acc_reg   <= acc_next;
            deg_reg   <= deg_next;
            tens_reg  <= tens_next;
            units_reg <= units_next;
            frac_reg  <= frac_next;
        end
    end

    // Once the count saturates the degree/minute parts are no longer used.
    always_comb begin
        coord.at_max = (acc_reg == sat_value);
        coord.deg    = deg_reg;
        coord.rem    = 24'(tens_reg) * 24'(TENS_WEIGHT) + 24'(units_reg) * 24'(INT_WEIGHT)
                     + 24'(frac_reg);
    end

endmodule

// ===== rtl/nrmc_sentence.sv =====
// Per-byte sentence tracker: header match, field split, time digits, flags and result trigger.
module nrmc_sentence (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     rx_byte,
    output logic           emit,
    output nrmc_pkg::fix_t fix
);
    import nrmc_pkg::*;

    logic [2:0]        header_reg, header_next;
    logic              match_reg, match_next;
    logic [2:0]        field_reg, field_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [2:0]        tcount_reg, tcount_next;
    logic [4:0]        hours_reg, hours_next;
    logic [5:0]        minutes_reg, minutes_next;
    logic [5:0]        seconds_reg, seconds_next;
    logic [2:0]        fcount_reg, fcount_next;
    logic              dot_reg, dot_next;
    logic              stop_reg, stop_next;
    logic              active_reg, active_next;
    logic              south_reg, south_next;
    logic              west_reg, west_next;
    logic              sent_reg, sent_next;
    logic              tpres_reg, tpres_next;
    logic              fstart_reg, fstart_next;

    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] tens_val;
    logic [6:0] hours_sum;
    logic [6:0] minutes_sum;
    logic [6:0] seconds_sum;
    logic       coord_int;
    logic       coord_frac;
    logic       emit_now;

    digit_cmd_t lat_cmd;
    digit_cmd_t lon_cmd;
    coord_t     lat_coord;
    coord_t     lon_coord;

    always_comb begin
        is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        digit       = rx_byte[3:0];
        tens_val    = 7'(digit) * 7'd10;
        hours_sum   = tcount_reg[0] ? 7'(hours_reg) + 7'(digit) : tens_val;
        minutes_sum = tcount_reg[0] ? 7'(minutes_reg) + 7'(digit) : tens_val;
        seconds_sum = tcount_reg[0] ? 7'(seconds_reg) + 7'(digit) : tens_val;

        header_next  = header_reg;
        match_next   = match_reg;
        field_next   = field_reg;
        char_next    = char_reg;
        tcount_next  = tcount_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        fcount_next  = fcount_reg;
        dot_next     = dot_reg;
        stop_next    = stop_reg;
        active_next  = active_reg;
        south_next   = south_reg;
        west_next    = west_reg;
        sent_next    = sent_reg;
        tpres_next   = tpres_reg;
        fstart_next  = fstart_reg;
        coord_int    = 1'b0;
        coord_frac   = 1'b0;
        emit_now     = 1'b0;
        lat_cmd      = '0;
        lon_cmd      = '0;

        if (step) begin
            if (rx_byte == CH_DOLLAR) begin
                header_next  = 3'd1;
                match_next   = 1'b0;
                field_next   = FLD_TIME;
                char_next    = CHAR_W'(1);
                tcount_next  = '0;
                hours_next   = '0;
                minutes_next = '0;
                seconds_next = '0;
                fcount_next  = '0;
                dot_next     = 1'b0;
                stop_next    = 1'b0;
                active_next  = 1'b0;
                south_next   = 1'b0;
                west_next    = 1'b0;
                sent_next    = 1'b0;
                tpres_next   = 1'b0;
                fstart_next  = 1'b0;
                lat_cmd.clear = 1'b1;
                lon_cmd.clear = 1'b1;
            end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
                if (match_reg && !sent_reg) begin
                    emit_now  = 1'b1;
                    sent_next = 1'b1;
                end
                header_next = '0;
                match_next  = 1'b0;
            end else if (!match_reg) begin
                if (header_reg != 3'd0) begin
                    if (header_reg < HDR_LEN) begin
                        header_next = (rx_byte == hdr_char(header_reg)) ?
                                      header_reg + 3'd1 : 3'd0;
                    end else if (rx_byte == CH_COMMA) begin
                        match_next  = 1'b1;
                        field_next  = FLD_TIME;
                        fstart_next = 1'b1;
                    end else begin
                        header_next = '0;
                    end
                    char_next = char_reg + CHAR_W'(1);
                end
            end else if (!sent_reg && char_reg < CHAR_W'(MAX_LEN)) begin
                char_next   = char_reg + CHAR_W'(1);
                fstart_next = 1'b0;
                unique case (field_reg) inside
                    FLD_TIME: begin
                        if (rx_byte != CH_COMMA) begin
                            tpres_next = 1'b1;
                        end
                        if (!stop_reg && tcount_reg < TIME_DIGITS) begin
                            if (!is_digit) begin
                                stop_next = 1'b1;
                            end else begin
                                tcount_next = tcount_reg + 3'd1;
                                if (tcount_reg < 3'd2) begin
                                    hours_next = (hours_sum > 7'(HOURS_MAX)) ?
                                                 HOURS_MAX : hours_sum[4:0];
                                end else if (tcount_reg < 3'd4) begin
                                    minutes_next = (minutes_sum > 7'(MINSEC_MAX)) ?
                                                   MINSEC_MAX : minutes_sum[5:0];
                                end else begin
                                    seconds_next = (seconds_sum > 7'(MINSEC_MAX)) ?
                                                   MINSEC_MAX : seconds_sum[5:0];
                                end
                            end
                        end
                    end
                    FLD_STATUS: begin
                        if (fstart_reg) begin
                            if (rx_byte == CH_A) begin
                                active_next = 1'b1;
                            end else begin
                                emit_now  = 1'b1;
                                sent_next = 1'b1;
                            end
                        end
                    end
                    FLD_LAT, FLD_LON: begin
                        if (!stop_reg) begin
                            if (rx_byte == CH_DOT && !dot_reg) begin
                                dot_next = 1'b1;
                            end else if (!is_digit) begin
                                stop_next = 1'b1;
                            end else if (!dot_reg) begin
                                coord_int = 1'b1;
                            end else if (fcount_reg < 3'(FRAC_DIGITS)) begin
                                coord_frac  = 1'b1;
                                fcount_next = fcount_reg + 3'd1;
                            end
                        end
                    end
                    FLD_NS: begin
                        if (fstart_reg && rx_byte != CH_N) begin
                            south_next = 1'b1;
                        end
                    end
                    FLD_EW: begin
                        if (fstart_reg) begin
                            west_next = (rx_byte != CH_E);
                            emit_now  = 1'b1;
                            sent_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (rx_byte == CH_COMMA && !emit_now) begin
                    field_next  = (field_reg == FLD_MAX) ? FLD_MAX : field_reg + 3'd1;
                    fstart_next = 1'b1;
                    dot_next    = 1'b0;
                    stop_next   = 1'b0;
                    fcount_next = '0;
                end
            end
        end

        lat_cmd.int_en   = coord_int && (field_reg == FLD_LAT);
        lat_cmd.frac_en  = coord_frac && (field_reg == FLD_LAT);
        lat_cmd.digit    = digit;
        lat_cmd.frac_idx = fcount_reg;
        lon_cmd.int_en   = coord_int && (field_reg == FLD_LON);
        lon_cmd.frac_en  = coord_frac && (field_reg == FLD_LON);
        lon_cmd.digit    = digit;
        lon_cmd.frac_idx = fcount_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= '0;
            match_reg   <= 1'b0;
            field_reg   <= FLD_TIME;
            char_reg    <= '0;
            tcount_reg  <= '0;
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            fcount_reg  <= '0;
            dot_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            active_reg  <= 1'b0;
            south_reg   <= 1'b0;
            west_reg    <= 1'b0;
            sent_reg    <= 1'b0;
            tpres_reg   <= 1'b0;
            fstart_reg  <= 1'b0;
        end else begin
            header_reg  <= header_next;
            match_reg   <= match_next;
            field_reg   <= field_next;
            char_reg    <= char_next;
            tcount_reg  <= tcount_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            fcount_reg  <= fcount_next;
            dot_reg     <= dot_next;
            stop_reg    <= stop_next;
            active_reg  <= active_next;
            south_reg   <= south_next;
            west_reg    <= west_next;
            sent_reg    <= sent_next;
            tpres_reg   <= tpres_next;
            fstart_reg  <= fstart_next;
        end
    end

    nrmc_coord_acc u_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (lat_cmd),
        .sat_value (LAT_ACC_MAX),
        .coord     (lat_coord)
    );

    nrmc_coord_acc u_lon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (lon_cmd),
        .sat_value (LON_ACC_MAX),
        .coord     (lon_coord)
    );

    // The hemisphere flags settle in the same cycle as the result is triggered.
    always_comb begin
        emit            = emit_now;
        fix.active      = active_next;
        fix.south       = south_next;
        fix.west        = west_next;
        fix.utc.present = tpres_reg;
        fix.utc.hours   = hours_reg;
        fix.utc.minutes = minutes_reg;
        fix.utc.seconds = seconds_reg;
        fix.lat         = lat_coord;
        fix.lon         = lon_coord;
    end

endmodule

// ===== rtl/nrmc_e7_conv.sv =====
// Two-step conversion of a coordinate's degree/minute parts to signed 1e-7 degrees.
module nrmc_e7_conv (
    input  logic             aclk,
    input  logic             load,
    input  nrmc_pkg::coord_t coord,
    input  logic             neg,
    input  logic [31:0]      limit,
    output logic [31:0]      e7
);
    import nrmc_pkg::*;

    logic [32:0] deg_e7_reg;
    logic [24:0] thirds_reg;
    logic        at_max_reg;
    logic        neg_reg;

    logic [51:0] rem_prod;
    logic [32:0] total;
    logic [31:0] mag;

    assign rem_prod = 52'(coord.rem) * 52'(FIVE_THIRDS_MUL);

    always_ff @(posedge aclk) begin
        if (load) begin
            deg_e7_reg <= 33'(coord.deg) * 33'(DEG_SCALE);
            thirds_reg <= rem_prod[THIRD_SHIFT +: 25];
            at_max_reg <= coord.at_max;
            neg_reg    <= neg;
        end
    end

    always_comb begin
        total = deg_e7_reg + 33'(thirds_reg);
        mag   = (at_max_reg || total > {1'b0, limit}) ? limit : total[31:0];
        e7    = neg_reg ? 32'(-mag) : mag;
    end

endmodule

// ===== rtl/nmea_rmc_position_parser.sv =====
// Top level of the RMC sentence parser: input register, parser, conversion pipeline and result register.
//
//  channel   handshake          payload
//  input     s_valid/s_ready    s_rx_byte (8)
//  result    m_valid/m_ready    m_fix_active, m_latitude_e7, m_longitude_e7, m_time_present,
//                               m_utc_hours, m_utc_minutes, m_utc_seconds
//
// One word is taken every cycle while s_ready is high; each byte is parsed from the input register
// once the capture stage is free. A result word crosses the capture, conversion and result registers.
// aresetn is synchronous; it clears all parsing state, so no sentence is in progress after it.
// When the result side stalls, the result, conversion and capture stages fill and the
// input stops taking words only once the stage behind the input register is full.
module nmea_rmc_position_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_fix_active,
    output logic signed [30:0] m_latitude_e7,
    output logic signed [31:0] m_longitude_e7,
    output logic               m_time_present,
    output logic [4:0]         m_utc_hours,
    output logic [5:0]         m_utc_minutes,
    output logic [5:0]         m_utc_seconds
);
    import nrmc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       cap_valid_reg;
    fix_t       cap_reg;
    logic       prod_valid_reg;
    logic       prod_active_reg;
    utc_t       prod_utc_reg;
    logic       m_valid_reg;

    logic               m_fix_active_reg;
    logic signed [30:0] m_latitude_e7_reg;
    logic signed [31:0] m_longitude_e7_reg;
    logic               m_time_present_reg;
    logic [4:0]         m_utc_hours_reg;
    logic [5:0]         m_utc_minutes_reg;
    logic [5:0]         m_utc_seconds_reg;

    logic prod_go;
    logic prod_free;
    logic cap_go;
    logic cap_free;
    logic proc_go;
    logic emit;
    fix_t fix;

    logic [31:0] lat_e7;
    logic [31:0] lon_e7;

    always_comb begin
        prod_go   = prod_valid_reg && (!m_valid_reg || m_ready);
        prod_free = !prod_valid_reg || prod_go;
        cap_go    = cap_valid_reg && prod_free;
        cap_free  = !cap_valid_reg || cap_go;
        proc_go   = in_valid_reg && cap_free;
        s_ready   = !in_valid_reg || proc_go;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cap_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            in_valid_reg   <= (s_valid && s_ready) || (in_valid_reg && !proc_go);
            cap_valid_reg  <= emit || (cap_valid_reg && !cap_go);
            prod_valid_reg <= cap_go || (prod_valid_reg && !prod_go);
            m_valid_reg    <= prod_go || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (emit) begin
            cap_reg <= fix;
        end
        if (cap_go) begin
            prod_active_reg <= cap_reg.active;
            prod_utc_reg    <= cap_reg.utc;
        end
        if (prod_go) begin
            m_fix_active_reg   <= prod_active_reg;
            m_latitude_e7_reg  <= prod_active_reg ? signed'(lat_e7[30:0]) : '0;
            m_longitude_e7_reg <= prod_active_reg ? signed'(lon_e7) : '0;
            m_time_present_reg <= prod_utc_reg.present;
            m_utc_hours_reg    <= prod_utc_reg.present ? prod_utc_reg.hours : '0;
            m_utc_minutes_reg  <= prod_utc_reg.present ? prod_utc_reg.minutes : '0;
            m_utc_seconds_reg  <= prod_utc_reg.present ? prod_utc_reg.seconds : '0;
        end
    end

    nrmc_sentence u_sentence (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc_go),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .fix     (fix)
    );

    nrmc_e7_conv u_lat_conv (
        .aclk  (aclk),
        .load  (cap_go),
        .coord (cap_reg.lat),
        .neg   (cap_reg.south),
        .limit (LAT_LIMIT),
        .e7    (lat_e7)
    );

    nrmc_e7_conv u_lon_conv (
        .aclk  (aclk),
        .load  (cap_go),
        .coord (cap_reg.lon),
        .neg   (cap_reg.west),
        .limit (LON_LIMIT),
        .e7    (lon_e7)
    );

    assign m_valid        = m_valid_reg;
    assign m_fix_active   = m_fix_active_reg;
    assign m_latitude_e7  = m_latitude_e7_reg;
    assign m_longitude_e7 = m_longitude_e7_reg;
    assign m_time_present = m_time_present_reg;
    assign m_utc_hours    = m_utc_hours_reg;
    assign m_utc_minutes  = m_utc_minutes_reg;
    assign m_utc_seconds  = m_utc_seconds_reg;

endmodule
